>>> rtl/prc_pkg.sv
package prc_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int TIME_W     = 32;
  localparam int DRIVE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MID_DEPTH  = 2;
  localparam int OUT_DEPTH  = 4;

  localparam int                 ANGLE_BAND = 2;
  localparam logic [DRIVE_W-1:0] DRIVE_DUTY = 8'd50;

  localparam logic [GAIN_W-1:0]         SAMPLE_PERIOD_RST = 16'd50;
  localparam logic signed [LIMIT_W-1:0] OUT_LOW_RST       = -16'sd255;
  localparam logic signed [LIMIT_W-1:0] OUT_HIGH_RST      = 16'sd255;

  typedef enum logic [1:0] {
    KIND_PID,
    KIND_ANGLE,
    KIND_INIT
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_MODE,
    REG_PROP_GAIN,
    REG_INTEGRAL_GAIN,
    REG_DERIV_GAIN,
    REG_SAMPLE_PERIOD,
    REG_OUT_LOW,
    REG_OUT_HIGH
  } reg_idx_t;

  typedef struct packed {
    logic                      angle_mode;
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         integral_gain;
    logic [GAIN_W-1:0]         deriv_gain;
    logic [GAIN_W-1:0]         sample_period;
    logic signed [LIMIT_W-1:0] out_low;
    logic signed [LIMIT_W-1:0] out_high;
  } cfg_t;

endpackage

>>> rtl/prc_fifo.sv
module prc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IW-1:0]    wr_ptr;
  logic [IW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost an item");
`endif

endmodule

>>> rtl/prc_cfg.sv
module prc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data,
  output prc_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_mode    <= 1'b0;
      cfg.prop_gain     <= '0;
      cfg.integral_gain <= '0;
      cfg.deriv_gain    <= '0;
      cfg.sample_period <= prc_pkg::SAMPLE_PERIOD_RST;
      cfg.out_low       <= prc_pkg::OUT_LOW_RST;
      cfg.out_high      <= prc_pkg::OUT_HIGH_RST;
    end else if (cfg_valid) begin
      case (prc_pkg::reg_idx_t'(cfg_index))
        prc_pkg::REG_ANGLE_MODE:    cfg.angle_mode    <= cfg_data[0];
        prc_pkg::REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data;
        prc_pkg::REG_INTEGRAL_GAIN: cfg.integral_gain <= cfg_data;
        prc_pkg::REG_DERIV_GAIN:    cfg.deriv_gain    <= cfg_data;
        prc_pkg::REG_SAMPLE_PERIOD: cfg.sample_period <= cfg_data;
        prc_pkg::REG_OUT_LOW:       cfg.out_low       <= signed'(cfg_data);
        prc_pkg::REG_OUT_HIGH:      cfg.out_high      <= signed'(cfg_data);
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/prc_front.sv
module prc_front #(
  parameter int DATA_WIDTH = prc_pkg::DATA_WIDTH
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_push,
  output logic                                            in_full,
  input  logic                                            mode,
  input  logic [prc_pkg::TIME_W-1:0]                      time_ms,
  input  logic signed [DATA_WIDTH-1:0]                    measured,
  input  logic signed [DATA_WIDTH-1:0]                    target,
  input  logic signed [DATA_WIDTH-1:0]                    prior_output,
  input  prc_pkg::cfg_t                                   cfg,
  input  logic                                            q_full,
  output logic                                            q_push,
  output prc_pkg::kind_t                                  f_kind,
  output logic [prc_pkg::TIME_W-1:0]                      f_time,
  output logic signed [DATA_WIDTH-1:0]                    f_meas,
  output logic signed [DATA_WIDTH-1:0]                    f_prior,
  output logic signed [DATA_WIDTH+prc_pkg::GAIN_W+1:0]    f_kp_err,
  output logic signed [DATA_WIDTH+prc_pkg::GAIN_W+1:0]    f_ki_err,
  output logic [prc_pkg::DRIVE_W-1:0]                     f_right,
  output logic [prc_pkg::DRIVE_W-1:0]                     f_left
);

  localparam int P = DATA_WIDTH + prc_pkg::GAIN_W + 2;

  logic                             valid;
  logic                             take;
  prc_pkg::kind_t                   kind_c;
  logic signed [DATA_WIDTH:0]       err;
  logic signed [prc_pkg::GAIN_W:0]  kp_s;
  logic signed [prc_pkg::GAIN_W:0]  ki_s;
  logic [prc_pkg::DRIVE_W-1:0]      right_c;
  logic [prc_pkg::DRIVE_W-1:0]      left_c;

  assign q_push  = valid && !q_full;
  assign in_full = valid && q_full;
  assign take    = in_push && !in_full;

  assign err  = (DATA_WIDTH + 1)'(target) - (DATA_WIDTH + 1)'(measured);
  assign kp_s = signed'({1'b0, cfg.prop_gain});
  assign ki_s = signed'({1'b0, cfg.integral_gain});

  always_comb begin
    if (mode) begin
      kind_c = prc_pkg::KIND_INIT;
    end else if (cfg.angle_mode) begin
      kind_c = prc_pkg::KIND_ANGLE;
    end else begin
      kind_c = prc_pkg::KIND_PID;
    end
  end

  always_comb begin
    right_c = '0;
    left_c  = '0;
    if (kind_c == prc_pkg::KIND_ANGLE) begin
      if (int'(target) < -prc_pkg::ANGLE_BAND) begin
        right_c = prc_pkg::DRIVE_DUTY;
      end else if (int'(target) > prc_pkg::ANGLE_BAND) begin
        left_c = prc_pkg::DRIVE_DUTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_kind   <= kind_c;
      f_time   <= time_ms;
      f_meas   <= measured;
      f_prior  <= prior_output;
      f_kp_err <= P'(kp_s) * P'(err);
      f_ki_err <= P'(ki_s) * P'(err);
      f_right  <= right_c;
      f_left   <= left_c;
    end
  end

endmodule

>>> rtl/prc_back.sv
module prc_back #(
  parameter int DATA_WIDTH = prc_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = prc_pkg::FRAC_BITS,
  parameter int OUT_DEPTH  = prc_pkg::OUT_DEPTH
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  prc_pkg::cfg_t                                 cfg,
  input  logic                                          q_empty,
  output logic                                          q_pop,
  input  prc_pkg::kind_t                                q_kind,
  input  logic [prc_pkg::TIME_W-1:0]                    q_time,
  input  logic signed [DATA_WIDTH-1:0]                  q_meas,
  input  logic signed [DATA_WIDTH-1:0]                  q_prior,
  input  logic signed [DATA_WIDTH+prc_pkg::GAIN_W+1:0]  q_kp_err,
  input  logic signed [DATA_WIDTH+prc_pkg::GAIN_W+1:0]  q_ki_err,
  input  logic [prc_pkg::DRIVE_W-1:0]                   q_right,
  input  logic [prc_pkg::DRIVE_W-1:0]                   q_left,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]                out_count,
  output logic                                          out_push,
  output logic signed [DATA_WIDTH-1:0]                  o_control,
  output logic                                          o_updated,
  output logic [prc_pkg::DRIVE_W-1:0]                   o_right,
  output logic [prc_pkg::DRIVE_W-1:0]                   o_left
);

  localparam int P     = DATA_WIDTH + prc_pkg::GAIN_W + 2;
  localparam int ACC_W = prc_pkg::LIMIT_W + FRAC_BITS;
  localparam int SW    = ((P > ACC_W) ? P : ACC_W) + 2;

  function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] x,
                                                 input logic signed [SW-1:0] lo,
                                                 input logic signed [SW-1:0] hi);
    if (x > hi) begin
      return hi;
    end
    if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  // loop state
  logic signed [ACC_W-1:0]        acc;
  logic signed [DATA_WIDTH-1:0]   last_meas;
  logic [prc_pkg::TIME_W-1:0]     last_time;
  logic                           first_pending;
  logic signed [DATA_WIDTH-1:0]   held;

  logic signed [SW-1:0]           lo_s;
  logic signed [SW-1:0]           hi_s;
  logic [prc_pkg::TIME_W-1:0]     elapsed;
  logic                           go;
  logic                           upd_c;
  logic signed [SW-1:0]           acc_pid;
  logic signed [SW-1:0]           acc_init;
  logic signed [DATA_WIDTH:0]     dmeas;
  logic signed [prc_pkg::GAIN_W:0] kd_s;

  logic                           a_valid;
  logic                           a_upd;
  logic signed [ACC_W-1:0]        a_acc;
  logic signed [P-1:0]            a_kp_err;
  logic signed [DATA_WIDTH:0]     a_dmeas;
  logic [prc_pkg::DRIVE_W-1:0]    a_right;
  logic [prc_pkg::DRIVE_W-1:0]    a_left;

  logic                           b_valid;
  logic                           b_upd;
  logic signed [ACC_W-1:0]        b_acc;
  logic signed [P-1:0]            b_kp_err;
  logic signed [P-1:0]            b_kd_prod;
  logic [prc_pkg::DRIVE_W-1:0]    b_right;
  logic [prc_pkg::DRIVE_W-1:0]    b_left;

  logic signed [SW-1:0]           sum;
  logic signed [SW-1:0]           sum_c;
  logic signed [SW-1:0]           sum_sh;
  logic signed [DATA_WIDTH-1:0]   new_out;

  assign lo_s = SW'(signed'(cfg.out_low)) <<< FRAC_BITS;
  assign hi_s = SW'(signed'(cfg.out_high)) <<< FRAC_BITS;
  assign kd_s = signed'({1'b0, cfg.deriv_gain});

  assign q_pop = !q_empty &&
                 ((int'(out_count) + int'(a_valid) + int'(b_valid)) < OUT_DEPTH);

  assign elapsed  = q_time - last_time;
  assign go       = first_pending || (elapsed >= prc_pkg::TIME_W'(cfg.sample_period));
  assign upd_c    = (q_kind == prc_pkg::KIND_PID) && go;
  assign acc_pid  = clamp(SW'(acc) + SW'(q_ki_err), lo_s, hi_s);
  assign acc_init = clamp(SW'(q_prior) <<< FRAC_BITS, lo_s, hi_s);
  assign dmeas    = (DATA_WIDTH + 1)'(q_meas) - (DATA_WIDTH + 1)'(last_meas);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      last_meas     <= '0;
      last_time     <= '0;
      first_pending <= 1'b1;
    end else if (q_pop) begin
      case (q_kind)
        prc_pkg::KIND_INIT: begin
          acc       <= ACC_W'(acc_init);
          last_meas <= q_meas;
        end
        prc_pkg::KIND_PID: begin
          if (go) begin
            acc           <= ACC_W'(acc_pid);
            last_meas     <= q_meas;
            last_time     <= q_time;
            first_pending <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= q_pop;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_upd    <= upd_c;
      a_acc    <= ACC_W'(acc_pid);
      a_kp_err <= q_kp_err;
      a_dmeas  <= dmeas;
      a_right  <= q_right;
      a_left   <= q_left;
    end
    if (a_valid) begin
      b_upd     <= a_upd;
      b_acc     <= a_acc;
      b_kp_err  <= a_kp_err;
      b_kd_prod <= P'(kd_s) * P'(a_dmeas);
      b_right   <= a_right;
      b_left    <= a_left;
    end
  end

  assign sum     = SW'(b_kp_err) + SW'(b_acc) - SW'(b_kd_prod);
  assign sum_c   = clamp(sum, lo_s, hi_s);
  assign sum_sh  = sum_c >>> FRAC_BITS;
  assign new_out = sum_sh[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (b_valid && b_upd) begin
      held <= new_out;
    end
  end

  assign out_push  = b_valid;
  assign o_control = b_upd ? new_out : held;
  assign o_updated = b_upd;
  assign o_right   = b_right;
  assign o_left    = b_left;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (int'(out_count) < OUT_DEPTH)) else $error("result queue overrun");
  a_pop_guard: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("pop from empty item queue");
  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    (q_pop && upd_c) |=> !first_pending) else $error("first update left pending");
  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !(b_valid && b_upd) |=> $stable(held)) else $error("held output moved without update");
`endif

endmodule

>>> rtl/pid_rudder_controller_unit.sv
// Fixed-point PID rudder controller, derivative on measurement. Push one item (mode, time stamp,
// measurement, setpoint, prior output) per clock while full is low; each item gives exactly one
// result in order. The sustained rate is one item per cycle while results are popped, set by the
// state loop in the back end (elapsed-time compare and integral add-and-clamp). An item passes
// the front register, item queue, update stage, derivative multiply, then output sum and clamp
// into a four-entry result queue. Configuration writes are always ready and must only be made
// while no item is in flight. Gains are unsigned with FRAC_BITS fraction bits and come
// pre-scaled by the sample period; out_low and out_high clamp both the integral and the output.
module pid_rudder_controller_unit #(
  parameter int DATA_WIDTH = prc_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = prc_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           mode,
  input  logic [prc_pkg::TIME_W-1:0]     time_ms,
  input  logic signed [DATA_WIDTH-1:0]   measured,
  input  logic signed [DATA_WIDTH-1:0]   target,
  input  logic signed [DATA_WIDTH-1:0]   prior_output,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [DATA_WIDTH-1:0]   control_out,
  output logic                           updated,
  output logic [prc_pkg::DRIVE_W-1:0]    right_drive,
  output logic [prc_pkg::DRIVE_W-1:0]    left_drive,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int P      = DATA_WIDTH + prc_pkg::GAIN_W + 2;
  localparam int KIND_W = $bits(prc_pkg::kind_t);
  localparam int MID_W  = KIND_W + prc_pkg::TIME_W + 2 * DATA_WIDTH + 2 * P
                          + 2 * prc_pkg::DRIVE_W;
  localparam int OUT_W  = DATA_WIDTH + 1 + 2 * prc_pkg::DRIVE_W;
  localparam int OCW    = $clog2(prc_pkg::OUT_DEPTH + 1);

  prc_pkg::cfg_t                  cfg;

  logic                           mid_push;
  logic                           mid_full;
  logic                           mid_pop;
  logic                           mid_empty;
  logic [MID_W-1:0]               mid_wr;
  logic [MID_W-1:0]               mid_rd;

  prc_pkg::kind_t                 f_kind;
  logic [prc_pkg::TIME_W-1:0]     f_time;
  logic signed [DATA_WIDTH-1:0]   f_meas;
  logic signed [DATA_WIDTH-1:0]   f_prior;
  logic signed [P-1:0]            f_kp_err;
  logic signed [P-1:0]            f_ki_err;
  logic [prc_pkg::DRIVE_W-1:0]    f_right;
  logic [prc_pkg::DRIVE_W-1:0]    f_left;

  logic [KIND_W-1:0]              q_kind_bits;
  prc_pkg::kind_t                 q_kind;
  logic [prc_pkg::TIME_W-1:0]     q_time;
  logic signed [DATA_WIDTH-1:0]   q_meas;
  logic signed [DATA_WIDTH-1:0]   q_prior;
  logic signed [P-1:0]            q_kp_err;
  logic signed [P-1:0]            q_ki_err;
  logic [prc_pkg::DRIVE_W-1:0]    q_right;
  logic [prc_pkg::DRIVE_W-1:0]    q_left;

  logic                           out_push;
  logic [OCW-1:0]                 out_count;
  logic [OUT_W-1:0]               out_wr;
  logic [OUT_W-1:0]               out_rd;
  logic signed [DATA_WIDTH-1:0]   o_control;
  logic                           o_updated;
  logic [prc_pkg::DRIVE_W-1:0]    o_right;
  logic [prc_pkg::DRIVE_W-1:0]    o_left;

  prc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  prc_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_push      (push),
    .in_full      (full),
    .mode         (mode),
    .time_ms      (time_ms),
    .measured     (measured),
    .target       (target),
    .prior_output (prior_output),
    .cfg          (cfg),
    .q_full       (mid_full),
    .q_push       (mid_push),
    .f_kind       (f_kind),
    .f_time       (f_time),
    .f_meas       (f_meas),
    .f_prior      (f_prior),
    .f_kp_err     (f_kp_err),
    .f_ki_err     (f_ki_err),
    .f_right      (f_right),
    .f_left       (f_left)
  );

  assign mid_wr = {f_kind, f_time, f_meas, f_prior, f_kp_err, f_ki_err, f_right, f_left};

  prc_fifo #(
    .WIDTH (MID_W),
    .DEPTH (prc_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty),
    .count   ()
  );

  assign {q_kind_bits, q_time, q_meas, q_prior, q_kp_err, q_ki_err, q_right, q_left} = mid_rd;
  assign q_kind = prc_pkg::kind_t'(q_kind_bits);

  prc_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .OUT_DEPTH  (prc_pkg::OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (mid_empty),
    .q_pop     (mid_pop),
    .q_kind    (q_kind),
    .q_time    (q_time),
    .q_meas    (q_meas),
    .q_prior   (q_prior),
    .q_kp_err  (q_kp_err),
    .q_ki_err  (q_ki_err),
    .q_right   (q_right),
    .q_left    (q_left),
    .out_count (out_count),
    .out_push  (out_push),
    .o_control (o_control),
    .o_updated (o_updated),
    .o_right   (o_right),
    .o_left    (o_left)
  );

  assign out_wr = {o_control, o_updated, o_right, o_left};

  prc_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (prc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (out_wr),
    .full    (),
    .pop     (pop),
    .rd_data (out_rd),
    .empty   (empty),
    .count   (out_count)
  );

  assign {control_out, updated, right_drive, left_drive} = out_rd;

endmodule

>>> tb/pid_rudder_controller_unit_tb.sv
`timescale 1ns / 100ps

module pid_rudder_controller_unit_tb;

  localparam int DW        = prc_pkg::DATA_WIDTH;
  localparam int FB        = prc_pkg::FRAC_BITS;
  localparam int TW        = prc_pkg::TIME_W;
  localparam int IDLE_MAX  = 3000;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 112;

  typedef struct {
    logic signed [DW-1:0]        ctl;
    logic                        upd;
    logic [prc_pkg::DRIVE_W-1:0] right;
    logic [prc_pkg::DRIVE_W-1:0] left;
  } drive_t;

  class drive_predictor_t;
    bit                       angle;
    bit [prc_pkg::GAIN_W-1:0] kp, ki, kd, period;
    logic signed [15:0]       lo_lim, hi_lim;
    longint                   integ;
    logic signed [DW-1:0]     last_meas;
    bit [TW-1:0]              last_stamp;
    bit                       first;
    logic signed [DW-1:0]     held;
    drive_t                   drive_q[$];
    int                       errors, items, updates, angle_hits;

    function new();
      angle = 0; kp = 0; ki = 0; kd = 0;
      period = prc_pkg::SAMPLE_PERIOD_RST;
      lo_lim = prc_pkg::OUT_LOW_RST;
      hi_lim = prc_pkg::OUT_HIGH_RST;
      integ = 0; last_meas = 0; last_stamp = 0; first = 1; held = 0;
      errors = 0; items = 0; updates = 0; angle_hits = 0;
    endfunction

    function void set_reg(prc_pkg::reg_idx_t idx, logic [prc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        prc_pkg::REG_ANGLE_MODE:    angle = data[0];
        prc_pkg::REG_PROP_GAIN:     kp = data;
        prc_pkg::REG_INTEGRAL_GAIN: ki = data;
        prc_pkg::REG_DERIV_GAIN:    kd = data;
        prc_pkg::REG_SAMPLE_PERIOD: period = data;
        prc_pkg::REG_OUT_LOW:       lo_lim = data;
        prc_pkg::REG_OUT_HIGH:      hi_lim = data;
        default: ;
      endcase
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    function void predict_step(bit md, bit [TW-1:0] stamp, logic signed [DW-1:0] meas,
                               logic signed [DW-1:0] targ, logic signed [DW-1:0] prior);
      longint lo, hi, err, dmeas, sum;
      bit [TW-1:0] elapsed;
      drive_t d;
      lo = longint'(lo_lim) <<< FB;
      hi = longint'(hi_lim) <<< FB;
      d.upd = 0;
      d.right = 0;
      d.left = 0;
      items++;
      if (md) begin
        integ = clip(longint'(prior) <<< FB, lo, hi);
        last_meas = meas;
      end else if (angle) begin
        if (targ < -prc_pkg::ANGLE_BAND) d.right = prc_pkg::DRIVE_DUTY;
        else if (targ > prc_pkg::ANGLE_BAND) d.left = prc_pkg::DRIVE_DUTY;
        if (d.right != 0 || d.left != 0) angle_hits++;
      end else begin
        elapsed = stamp - last_stamp;
        if (first || elapsed >= TW'(period)) begin
          err = longint'(targ) - longint'(meas);
          dmeas = longint'(meas) - longint'(last_meas);
          integ = clip(integ + longint'(ki) * err, lo, hi);
          sum = longint'(kp) * err + integ - longint'(kd) * dmeas;
          sum = clip(sum, lo, hi);
          held = DW'(sum >>> FB);
          last_meas = meas;
          last_stamp = stamp;
          first = 0;
          d.upd = 1;
          updates++;
        end
      end
      d.ctl = held;
      drive_q.push_back(d);
    endfunction

    function void compare_drive(logic signed [DW-1:0] ctl, logic upd,
                                logic [prc_pkg::DRIVE_W-1:0] right,
                                logic [prc_pkg::DRIVE_W-1:0] left);
      drive_t d;
      if (drive_q.size() == 0) begin
        $display("%0t: result with none expected, control_out %0d", $time, ctl);
        errors++;
        return;
      end
      d = drive_q.pop_front();
      if (ctl !== d.ctl) begin
        $display("%0t: control_out expected %0d actual %0d", $time, d.ctl, ctl);
        errors++;
      end
      if (upd !== d.upd) begin
        $display("%0t: updated expected %0d actual %0d", $time, d.upd, upd);
        errors++;
      end
      if (right !== d.right) begin
        $display("%0t: right_drive expected %0d actual %0d", $time, d.right, right);
        errors++;
      end
      if (left !== d.left) begin
        $display("%0t: left_drive expected %0d actual %0d", $time, d.left, left);
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              push;
  logic                              full;
  logic                              mode;
  logic [TW-1:0]                     time_ms;
  logic signed [DW-1:0]              measured;
  logic signed [DW-1:0]              target;
  logic signed [DW-1:0]              prior_output;
  logic                              empty;
  logic                              pop;
  logic signed [DW-1:0]              control_out;
  logic                              updated;
  logic [prc_pkg::DRIVE_W-1:0]       right_drive;
  logic [prc_pkg::DRIVE_W-1:0]       left_drive;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data;

  drive_predictor_t  rudder;
  int                idle_cycles;
  bit                busy;
  bit                calm;
  int                hold_left;
  int                settings_seen;
  bit [TW-1:0]       clock_ms;

  pid_rudder_controller_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .time_ms      (time_ms),
    .measured     (measured),
    .target       (target),
    .prior_output (prior_output),
    .empty        (empty),
    .pop          (pop),
    .control_out  (control_out),
    .updated      (updated),
    .right_drive  (right_drive),
    .left_drive   (left_drive),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return DW'($urandom);
      3:       return DW'(int'($urandom_range(0, 10)) - 5);
      default: return DW'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // sample at the rising edge: predict, check, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      busy = 0;
      if (cfg_valid && cfg_ready) begin
        rudder.set_reg(prc_pkg::reg_idx_t'(cfg_index), cfg_data);
        busy = 1;
      end
      if (push && !full) begin
        rudder.predict_step(mode, time_ms, measured, target, prior_output);
        busy = 1;
      end
      if (pop && !empty) begin
        rudder.compare_drive(control_out, updated, right_drive, left_drive);
        busy = 1;
      end
      if (busy) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_MAX);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: stall at random
  initial begin
    pop = 0;
    hold_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        pop = 0;
        hold_left--;
      end else begin
        pop = 1;
        if (!calm && $urandom_range(0, 2) == 0) hold_left = pick_gap();
      end
      @(negedge clk);
    end
  end

  task automatic push_item(bit md, bit [TW-1:0] stamp, logic signed [DW-1:0] meas,
                           logic signed [DW-1:0] targ, logic signed [DW-1:0] prior);
    int gap;
    mode = md;
    time_ms = stamp;
    measured = meas;
    target = targ;
    prior_output = prior;
    push = 1;
    do @(posedge clk); while (full);
    @(negedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      push = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(prc_pkg::reg_idx_t idx, logic [prc_pkg::CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic settle(int extra);
    push = 0;
    while (rudder.drive_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic load_settings(bit ang, logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                               logic [15:0] per, logic [15:0] lo, logic [15:0] hi);
    settle(8);
    write_reg(prc_pkg::REG_ANGLE_MODE, {15'd0, ang});
    write_reg(prc_pkg::REG_PROP_GAIN, kp);
    write_reg(prc_pkg::REG_INTEGRAL_GAIN, ki);
    write_reg(prc_pkg::REG_DERIV_GAIN, kd);
    write_reg(prc_pkg::REG_SAMPLE_PERIOD, per);
    write_reg(prc_pkg::REG_OUT_LOW, lo);
    write_reg(prc_pkg::REG_OUT_HIGH, hi);
    cfg_valid = 0;
    settings_seen++;
  endtask

  task automatic run_phase(int ph);
    bit ang;
    logic [15:0] kp, ki, kd, per;
    logic signed [15:0] lo, hi, t;
    int step;
    ang = 0;
    kp = 16'($urandom_range(0, 16'h0400));
    ki = 16'($urandom_range(0, 16'h0100));
    kd = 16'($urandom_range(0, 16'h0400));
    per = 16'($urandom_range(1, 100));
    lo = -16'sd1000 - 16'($urandom_range(0, 2000));
    hi = 16'sd1000 + 16'($urandom_range(0, 2000));
    case (ph)
      1: begin
        kp = 16'hFFFF; ki = 16'hFFFF; kd = 16'hFFFF; per = 16'd1;
        lo = 16'sh8000; hi = 16'sh7FFF;
      end
      2: begin
        kp = 0; ki = 0; kd = 0; per = 16'hFFFF;
        lo = prc_pkg::OUT_LOW_RST; hi = prc_pkg::OUT_HIGH_RST;
      end
      3: begin
        per = 0; lo = 16'sd500; hi = -16'sd500;
      end
      4: ang = 1;
      5, 7: begin
        kp = 16'($urandom); ki = 16'($urandom); kd = 16'($urandom);
        per = (ph == 7) ? 16'($urandom) : 16'($urandom_range(1, 200));
        lo = 16'($urandom); hi = 16'($urandom);
        if (ph == 5 && lo > hi) begin
          t = lo; lo = hi; hi = t;
        end
      end
      6: begin
        lo = 16'($urandom); hi = lo;
      end
      default: ;
    endcase
    load_settings(ang, kp, ki, kd, per, lo, hi);
    calm = ($urandom_range(0, 3) == 0);
    for (step = 0; step < PHASE_LEN; step++) begin
      case ($urandom_range(0, 19))
        0:       clock_ms += $urandom;
        1:       ;
        default: clock_ms += $urandom_range(0, 2 * int'(per) + 2);
      endcase
      push_item($urandom_range(0, 9) == 0, clock_ms, pick_value(), pick_value(), pick_value());
    end
  endtask

  initial begin
    rudder = new();
    clk = 0;
    rst = 1;
    push = 0;
    mode = 0;
    time_ms = 0;
    measured = 0;
    target = 0;
    prior_output = 0;
    cfg_valid = 0;
    cfg_index = prc_pkg::REG_ANGLE_MODE;
    cfg_data = 0;
    calm = 0;
    settings_seen = 1;
    repeat (12) @(negedge clk);
    rst = 0;

    // reset settings: seeded integral, first step, period gate
    push_item(1, 0, 100, 0, 1000);
    push_item(0, 10, 0, 0, 0);
    push_item(0, 30, 0, 0, 0);
    push_item(0, 80, 0, 0, 0);

    load_settings(0, 16'h0100, 16'h0080, 16'h0040, 16'd10, -16'sd1000, 16'sd1000);
    push_item(0, 100, 16'sh8000, 16'sh7FFF, 0);
    push_item(0, 110, 16'sh7FFF, 16'sh8000, 0);
    push_item(1, 115, 0, 0, 16'sh8000);
    push_item(1, 120, 16'sh7FFF, 0, 16'sh7FFF);
    push_item(0, 32'hFFFF_FFF0, 5, 5, 0);
    push_item(0, 32'h0000_0005, 5, 40, 0);
    push_item(0, 32'h0000_0006, 5, 40, 0);
    push_item(0, 32'h0000_000F, -7, 40, 0);

    load_settings(1, 16'h0100, 16'h0080, 16'h0040, 16'd10, -16'sd1000, 16'sd1000);
    push_item(0, 200, 0, 16'sh8000, 0);
    push_item(0, 201, 0, -3, 0);
    push_item(0, 202, 0, -2, 0);
    push_item(0, 203, 0, 0, 0);
    push_item(0, 204, 0, 2, 0);
    push_item(0, 205, 0, 3, 0);
    push_item(0, 206, 0, 16'sh7FFF, 0);
    push_item(1, 207, 9, 0, 12);

    clock_ms = 300;
    for (int ph = 0; ph < N_PHASES; ph++) run_phase(ph);

    settle(20);
    $display("Covered %0d items over %0d register settings, including inverted limits,",
             rudder.items, settings_seen);
    $display("zero and maximum periods and time wrap: %0d PID updates, %0d angle drives.",
             rudder.updates, rudder.angle_hits);
    if (rudder.errors == 0 && rudder.drive_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
